// ===== hw/rtl/chc_pkg.sv =====
// ----------------------------------------------------------------------------
// chc_pkg
// Shared types, sizes and codes of the canonical code table block.
// ----------------------------------------------------------------------------
package chc_pkg;

  localparam int NUM_SYMBOLS = 256;
  localparam int MAX_LEN     = 32;
  localparam int NLEN        = MAX_LEN + 1;
  localparam int SYM_W       = 8;
  localparam int LEN_W       = 6;
  localparam int LVL_AW      = 6;
  localparam int CNT_W       = 9;
  localparam int CODE_W      = 32;

  localparam logic [2:0] CMD_LOAD   = 3'd0;
  localparam logic [2:0] CMD_BUILD  = 3'd1;
  localparam logic [2:0] CMD_ENCODE = 3'd2;
  localparam logic [2:0] CMD_DECODE = 3'd3;
  localparam logic [2:0] CMD_CLEAR  = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_TOO_LONG  = 2'd2;
  localparam logic [1:0] ST_NOT_BUILT = 2'd3;

  typedef struct packed {
    logic [2:0]        cmd;
    logic [SYM_W-1:0]  symbol;
    logic [LEN_W-1:0]  word_len;
    logic [CODE_W-1:0] code_bits;
  } in_item_t;

  typedef struct packed {
    logic [SYM_W-1:0]  found_symbol;
    logic [CODE_W-1:0] out_code;
    logic [LEN_W-1:0]  out_length;
    logic [1:0]        status;
  } out_item_t;

  // Requests to the per-symbol memories.
  typedef struct packed {
    logic              len_we;
    logic [SYM_W-1:0]  len_waddr;
    logic [LEN_W-1:0]  len_wdata;
    logic              len_re;
    logic [SYM_W-1:0]  len_raddr;
    logic              code_we;
    logic [SYM_W-1:0]  code_waddr;
    logic [CODE_W-1:0] code_wdata;
    logic              code_re;
    logic [SYM_W-1:0]  code_raddr;
    logic              sort_we;
    logic [SYM_W-1:0]  sort_waddr;
    logic [SYM_W-1:0]  sort_wdata;
    logic              sort_re;
    logic [SYM_W-1:0]  sort_raddr;
  } sym_req_t;

  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [CODE_W-1:0] code;
    logic [SYM_W-1:0]  sort;
  } sym_rsp_t;

  // Requests to the per-length memories.
  typedef struct packed {
    logic              re;
    logic [LVL_AW-1:0] raddr;
    logic [LVL_AW-1:0] waddr;
    logic              cnt_we;
    logic [CNT_W-1:0]  cnt_wdata;
    logic              frank_we;
    logic              cursor_we;
    logic [CNT_W-1:0]  rank_wdata;
    logic              fcode_we;
    logic [CODE_W-1:0] fcode_wdata;
  } lvl_req_t;

  typedef struct packed {
    logic [CNT_W-1:0]  cnt;
    logic [CNT_W-1:0]  frank;
    logic [CNT_W-1:0]  cursor;
    logic [CODE_W-1:0] fcode;
  } lvl_rsp_t;

endpackage

// ===== hw/rtl/canonical_huffman_table.sv =====
// ----------------------------------------------------------------------------
// canonical_huffman_table
// Canonical prefix code table for bytes: load, build, encode, decode, clear.
// ----------------------------------------------------------------------------
// Every accepted beat yields exactly one result beat. Load, clear and unknown
// commands go straight to the result holding register; encode first reads
// the symbol memories, and decode reads the length memories and, on a hit,
// the sorted symbol list. A build walks the tables one memory access at a
// time: it clears the per-length counts, counts the present symbols, forms
// the rank prefix sum, places the symbols in sorted order and assigns codes.
// The input side is ready whenever the sequencer is idle, even while the
// previous result beat still waits on out_ready. Present marks live in
// flip-flops and are cleared at once by reset or by a clear beat; the
// memories need no clearing pass because nothing is read from them before a
// build has written it.
module canonical_huffman_table (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  chc_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output chc_pkg::out_item_t out_data
);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_RESP = 5'd1;
  localparam logic [4:0] S_ENC  = 5'd2;
  localparam logic [4:0] S_DEC1 = 5'd3;
  localparam logic [4:0] S_DEC2 = 5'd4;
  localparam logic [4:0] S_BCLR = 5'd5;
  localparam logic [4:0] S_CNA  = 5'd6;
  localparam logic [4:0] S_CNB  = 5'd7;
  localparam logic [4:0] S_CNC  = 5'd8;
  localparam logic [4:0] S_PFA  = 5'd9;
  localparam logic [4:0] S_PFB  = 5'd10;
  localparam logic [4:0] S_PLA  = 5'd11;
  localparam logic [4:0] S_PLB  = 5'd12;
  localparam logic [4:0] S_PLC  = 5'd13;
  localparam logic [4:0] S_ASA  = 5'd14;
  localparam logic [4:0] S_ASB  = 5'd15;
  localparam logic [4:0] S_ASC  = 5'd16;
  localparam logic [4:0] S_ASD  = 5'd17;

  localparam logic [chc_pkg::LVL_AW-1:0] LAST_LVL = chc_pkg::LVL_AW'(chc_pkg::MAX_LEN);

  // Control registers.
  logic [4:0]                       state_r, state_nxt;
  logic [chc_pkg::NUM_SYMBOLS-1:0]  present_r, present_nxt;
  logic                             built_r, built_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic [chc_pkg::SYM_W:0]          s_r, s_nxt;
  logic [chc_pkg::LVL_AW-1:0]       l_r, l_nxt;
  logic [chc_pkg::CNT_W-1:0]        rank_r, rank_nxt;
  logic [chc_pkg::CNT_W-1:0]        i_r, i_nxt;
  logic                             first_r, first_nxt;
  logic                             newlen_r, newlen_nxt;

  // Payload registers.
  chc_pkg::in_item_t                item_r, item_nxt;
  chc_pkg::out_item_t               res_r, res_nxt;
  chc_pkg::out_item_t               out_r, out_nxt;
  logic [chc_pkg::LEN_W-1:0]        lt_r, lt_nxt;
  logic [chc_pkg::LEN_W-1:0]        cur_r, cur_nxt;
  logic [chc_pkg::SYM_W-1:0]        sym_r, sym_nxt;
  logic [chc_pkg::CODE_W-1:0]       code_r, code_nxt;

  chc_pkg::sym_req_t sym_req;
  chc_pkg::sym_rsp_t sym_rsp;
  chc_pkg::lvl_req_t lvl_req;
  chc_pkg::lvl_rsp_t lvl_rsp;

  logic                             acc;
  logic                             out_free;
  logic [chc_pkg::CODE_W-1:0]       diff;
  logic                             dec_hit;
  logic [chc_pkg::LEN_W-1:0]        grow;
  logic [chc_pkg::CODE_W-1:0]       code_step;
  logic [chc_pkg::CNT_W-1:0]        i_inc;
  logic                             sym_in_range;
  logic                             len_ok;

  chc_sym_mem u_sym_mem (
    .clk (clk),
    .req (sym_req),
    .rsp (sym_rsp)
  );

  chc_lvl_mem u_lvl_mem (
    .clk (clk),
    .req (lvl_req),
    .rsp (lvl_rsp)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign acc       = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign sym_in_range = ({1'b0, in_data.symbol} < (chc_pkg::SYM_W + 1)'(chc_pkg::NUM_SYMBOLS));
  assign len_ok       = (in_data.word_len <= chc_pkg::LEN_W'(chc_pkg::MAX_LEN));

  // A decode hits when the code lies within the run of codes of its length.
  assign diff    = item_r.code_bits - lvl_rsp.fcode;
  assign dec_hit = (lvl_rsp.cnt != '0) && (diff < chc_pkg::CODE_W'(lvl_rsp.cnt));

  // Canonical step: next code is (code + 1) shifted by the growth in length.
  assign grow      = (sym_rsp.len >= cur_r) ? (sym_rsp.len - cur_r) : '0;
  assign code_step = (grow >= chc_pkg::LEN_W'(32)) ? '0 : ((code_r + 1'b1) << grow[4:0]);
  assign i_inc     = i_r + 1'b1;

  always_comb begin
    state_nxt     = state_r;
    present_nxt   = present_r;
    built_nxt     = built_r;
    out_valid_nxt = out_valid_r;
    s_nxt         = s_r;
    l_nxt         = l_r;
    rank_nxt      = rank_r;
    i_nxt         = i_r;
    first_nxt     = first_r;
    newlen_nxt    = newlen_r;
    item_nxt      = item_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    lt_nxt        = lt_r;
    cur_nxt       = cur_r;
    sym_nxt       = sym_r;
    code_nxt      = code_r;
    sym_req       = '0;
    lvl_req       = '0;

    // The result register drains whenever the far side takes the beat.
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          item_nxt  = in_data;
          res_nxt   = '0;
          state_nxt = S_RESP;
          unique case (in_data.cmd)
            chc_pkg::CMD_LOAD: begin
              if (!len_ok) begin
                res_nxt.status = chc_pkg::ST_TOO_LONG;
              end else if (!sym_in_range) begin
                res_nxt.status = chc_pkg::ST_NOT_FOUND;
              end else begin
                present_nxt[in_data.symbol] = 1'b1;
                sym_req.len_we    = 1'b1;
                sym_req.len_waddr = in_data.symbol;
                sym_req.len_wdata = in_data.word_len;
                built_nxt         = 1'b0;
              end
            end
            chc_pkg::CMD_BUILD: begin
              l_nxt     = '0;
              state_nxt = S_BCLR;
            end
            chc_pkg::CMD_ENCODE: begin
              if (!built_r) begin
                res_nxt.status = chc_pkg::ST_NOT_BUILT;
              end else if (!sym_in_range || !present_r[in_data.symbol]) begin
                res_nxt.status = chc_pkg::ST_NOT_FOUND;
              end else begin
                sym_req.len_re     = 1'b1;
                sym_req.len_raddr  = in_data.symbol;
                sym_req.code_re    = 1'b1;
                sym_req.code_raddr = in_data.symbol;
                state_nxt          = S_ENC;
              end
            end
            chc_pkg::CMD_DECODE: begin
              if (!built_r) begin
                res_nxt.status = chc_pkg::ST_NOT_BUILT;
              end else if (!len_ok) begin
                res_nxt.status = chc_pkg::ST_TOO_LONG;
              end else begin
                lvl_req.re    = 1'b1;
                lvl_req.raddr = in_data.word_len;
                state_nxt     = S_DEC1;
              end
            end
            chc_pkg::CMD_CLEAR: begin
              present_nxt = '0;
              built_nxt   = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end

      S_RESP: begin
        if (out_free) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      S_ENC: begin
        res_nxt.out_code   = sym_rsp.code;
        res_nxt.out_length = sym_rsp.len;
        state_nxt          = S_RESP;
      end

      S_DEC1: begin
        if (dec_hit) begin
          sym_req.sort_re    = 1'b1;
          sym_req.sort_raddr = lvl_rsp.frank[chc_pkg::SYM_W-1:0] + diff[chc_pkg::SYM_W-1:0];
          state_nxt          = S_DEC2;
        end else begin
          res_nxt.status = chc_pkg::ST_NOT_FOUND;
          state_nxt      = S_RESP;
        end
      end

      S_DEC2: begin
        res_nxt.found_symbol = sym_rsp.sort;
        state_nxt            = S_RESP;
      end

      S_BCLR: begin
        lvl_req.cnt_we    = 1'b1;
        lvl_req.waddr     = l_r;
        lvl_req.cnt_wdata = '0;
        if (l_r == LAST_LVL) begin
          s_nxt     = '0;
          state_nxt = S_CNA;
        end else begin
          l_nxt = l_r + 1'b1;
        end
      end

      S_CNA: begin
        if (s_r[chc_pkg::SYM_W]) begin
          l_nxt     = '0;
          rank_nxt  = '0;
          state_nxt = S_PFA;
        end else if (present_r[s_r[chc_pkg::SYM_W-1:0]]) begin
          sym_req.len_re    = 1'b1;
          sym_req.len_raddr = s_r[chc_pkg::SYM_W-1:0];
          state_nxt         = S_CNB;
        end else begin
          s_nxt = s_r + 1'b1;
        end
      end

      S_CNB: begin
        lt_nxt        = sym_rsp.len;
        lvl_req.re    = 1'b1;
        lvl_req.raddr = sym_rsp.len;
        state_nxt     = S_CNC;
      end

      S_CNC: begin
        lvl_req.cnt_we    = 1'b1;
        lvl_req.waddr     = lt_r;
        lvl_req.cnt_wdata = lvl_rsp.cnt + 1'b1;
        s_nxt             = s_r + 1'b1;
        state_nxt         = S_CNA;
      end

      S_PFA: begin
        lvl_req.re    = 1'b1;
        lvl_req.raddr = l_r;
        state_nxt     = S_PFB;
      end

      S_PFB: begin
        lvl_req.frank_we   = 1'b1;
        lvl_req.cursor_we  = 1'b1;
        lvl_req.waddr      = l_r;
        lvl_req.rank_wdata = rank_r;
        rank_nxt           = rank_r + lvl_rsp.cnt;
        if (l_r == LAST_LVL) begin
          s_nxt     = '0;
          state_nxt = S_PLA;
        end else begin
          l_nxt     = l_r + 1'b1;
          state_nxt = S_PFA;
        end
      end

      S_PLA: begin
        if (s_r[chc_pkg::SYM_W]) begin
          state_nxt = S_ASA;
        end else if (present_r[s_r[chc_pkg::SYM_W-1:0]]) begin
          sym_req.len_re    = 1'b1;
          sym_req.len_raddr = s_r[chc_pkg::SYM_W-1:0];
          state_nxt         = S_PLB;
        end else begin
          s_nxt = s_r + 1'b1;
        end
      end

      S_PLB: begin
        lt_nxt        = sym_rsp.len;
        lvl_req.re    = 1'b1;
        lvl_req.raddr = sym_rsp.len;
        state_nxt     = S_PLC;
      end

      S_PLC: begin
        sym_req.sort_we    = 1'b1;
        sym_req.sort_waddr = lvl_rsp.cursor[chc_pkg::SYM_W-1:0];
        sym_req.sort_wdata = s_r[chc_pkg::SYM_W-1:0];
        lvl_req.cursor_we  = 1'b1;
        lvl_req.waddr      = lt_r;
        lvl_req.rank_wdata = lvl_rsp.cursor + 1'b1;
        s_nxt              = s_r + 1'b1;
        state_nxt          = S_PLA;
      end

      S_ASA: begin
        if (rank_r == '0) begin
          built_nxt = 1'b1;
          state_nxt = S_RESP;
        end else begin
          sym_req.sort_re    = 1'b1;
          sym_req.sort_raddr = '0;
          i_nxt              = '0;
          code_nxt           = '0;
          first_nxt          = 1'b1;
          state_nxt          = S_ASB;
        end
      end

      S_ASB: begin
        sym_nxt           = sym_rsp.sort;
        sym_req.len_re    = 1'b1;
        sym_req.len_raddr = sym_rsp.sort;
        state_nxt         = S_ASC;
      end

      S_ASC: begin
        cur_nxt = sym_rsp.len;
        if (first_r) begin
          first_nxt  = 1'b0;
          newlen_nxt = 1'b1;
        end else begin
          newlen_nxt = (sym_rsp.len != cur_r);
          code_nxt   = code_step;
          i_nxt      = i_inc;
        end
        state_nxt = S_ASD;
      end

      S_ASD: begin
        sym_req.code_we    = 1'b1;
        sym_req.code_waddr = sym_r;
        sym_req.code_wdata = code_r;
        lvl_req.fcode_we    = newlen_r;
        lvl_req.waddr       = cur_r;
        lvl_req.fcode_wdata = code_r;
        if (i_inc < rank_r) begin
          sym_req.sort_re    = 1'b1;
          sym_req.sort_raddr = i_inc[chc_pkg::SYM_W-1:0];
          state_nxt          = S_ASB;
        end else begin
          built_nxt = 1'b1;
          state_nxt = S_RESP;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      present_r   <= '0;
      built_r     <= 1'b0;
      out_valid_r <= 1'b0;
      s_r         <= '0;
      l_r         <= '0;
      rank_r      <= '0;
      i_r         <= '0;
      first_r     <= 1'b0;
      newlen_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      present_r   <= present_nxt;
      built_r     <= built_nxt;
      out_valid_r <= out_valid_nxt;
      s_r         <= s_nxt;
      l_r         <= l_nxt;
      rank_r      <= rank_nxt;
      i_r         <= i_nxt;
      first_r     <= first_nxt;
      newlen_r    <= newlen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
    lt_r   <= lt_nxt;
    cur_r  <= cur_nxt;
    sym_r  <= sym_nxt;
    code_r <= code_nxt;
  end

`ifndef SYNTHESIS
  // An accepted beat always leaves the sequencer busy.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> !in_ready)
    else $error("input accepted back to back");

  // The table becomes usable only at the end of the code assignment walk.
  a_built_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(built_r) |-> ($past(state_r) == S_ASA || $past(state_r) == S_ASD))
    else $error("built flag set outside the build");

  // The rank total can never exceed the number of symbols.
  a_rank_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rank_r <= chc_pkg::CNT_W'(chc_pkg::NUM_SYMBOLS))
    else $error("rank total overflow");

  // The second decode step always follows a sorted list read.
  a_dec_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DEC2) |-> $past(sym_req.sort_re))
    else $error("decode without sorted list read");
`endif

endmodule

// ===== hw/rtl/chc_sym_mem.sv =====
// ----------------------------------------------------------------------------
// chc_sym_mem
// Per-symbol memories: code length, code word and the sorted symbol list.
// ----------------------------------------------------------------------------
module chc_sym_mem (
  input  logic             clk,
  input  chc_pkg::sym_req_t req,
  output chc_pkg::sym_rsp_t rsp
);

  logic [chc_pkg::LEN_W-1:0]  len_mem  [0:chc_pkg::NUM_SYMBOLS-1];
  logic [chc_pkg::CODE_W-1:0] code_mem [0:chc_pkg::NUM_SYMBOLS-1];
  logic [chc_pkg::SYM_W-1:0]  sort_mem [0:chc_pkg::NUM_SYMBOLS-1];

  logic [chc_pkg::LEN_W-1:0]  len_q_r;
  logic [chc_pkg::CODE_W-1:0] code_q_r;
  logic [chc_pkg::SYM_W-1:0]  sort_q_r;

  always_ff @(posedge clk) begin
    if (req.len_we) begin
      len_mem[req.len_waddr] <= req.len_wdata;
    end
    if (req.len_re) begin
      len_q_r <= len_mem[req.len_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (req.code_we) begin
      code_mem[req.code_waddr] <= req.code_wdata;
    end
    if (req.code_re) begin
      code_q_r <= code_mem[req.code_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (req.sort_we) begin
      sort_mem[req.sort_waddr] <= req.sort_wdata;
    end
    if (req.sort_re) begin
      sort_q_r <= sort_mem[req.sort_raddr];
    end
  end

  assign rsp.len  = len_q_r;
  assign rsp.code = code_q_r;
  assign rsp.sort = sort_q_r;

endmodule

// ===== hw/rtl/chc_lvl_mem.sv =====
// ----------------------------------------------------------------------------
// chc_lvl_mem
// Per-length memories: symbol count, first rank, placement cursor, first code.
// ----------------------------------------------------------------------------
module chc_lvl_mem (
  input  logic             clk,
  input  chc_pkg::lvl_req_t req,
  output chc_pkg::lvl_rsp_t rsp
);

  logic [chc_pkg::CNT_W-1:0]  cnt_mem    [0:chc_pkg::NLEN-1];
  logic [chc_pkg::CNT_W-1:0]  frank_mem  [0:chc_pkg::NLEN-1];
  logic [chc_pkg::CNT_W-1:0]  cursor_mem [0:chc_pkg::NLEN-1];
  logic [chc_pkg::CODE_W-1:0] fcode_mem  [0:chc_pkg::NLEN-1];

  chc_pkg::lvl_rsp_t q_r;

  always_ff @(posedge clk) begin
    if (req.cnt_we) begin
      cnt_mem[req.waddr] <= req.cnt_wdata;
    end
    if (req.frank_we) begin
      frank_mem[req.waddr] <= req.rank_wdata;
    end
    if (req.cursor_we) begin
      cursor_mem[req.waddr] <= req.rank_wdata;
    end
    if (req.fcode_we) begin
      fcode_mem[req.waddr] <= req.fcode_wdata;
    end
    if (req.re) begin
      q_r.cnt    <= cnt_mem[req.raddr];
      q_r.frank  <= frank_mem[req.raddr];
      q_r.cursor <= cursor_mem[req.raddr];
      q_r.fcode  <= fcode_mem[req.raddr];
    end
  end

  assign rsp = q_r;

endmodule

// ===== tb/canonical_huffman_table_test.sv =====
// ----------------------------------------------------------------------------
// canonical_huffman_table_test
// Self-checking bench for the canonical prefix code table.
// ----------------------------------------------------------------------------
// Beats of load, build, encode, decode and clear are driven into the block.
// A behavioral copy of the table predicts each result beat, and a checker
// compares every result beat, field by field, with the oldest prediction.
// Both channels idle at random in two phases, not at all in the third; a
// hold-off of the result side fills up the block and stalls its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module canonical_huffman_table_test;

  localparam int WATCHDOG_LIMIT = 20000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  chc_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_ready;
  chc_pkg::out_item_t out_data;

  canonical_huffman_table dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // Shadow copy of the table contents.
  bit             sym_present[256];
  bit [5:0]       sym_len[256];
  bit [31:0]      sym_code[256];
  int unsigned    len_count[chc_pkg::NLEN];
  bit [31:0]      len_first_code[chc_pkg::NLEN];
  int unsigned    len_first_rank[chc_pkg::NLEN];
  bit [7:0]       rank_symbol[256];
  bit             table_built;

  chc_pkg::out_item_t pending_results[$];
  int             error_count;
  int             send_idle_pct;
  int             recv_idle_pct;
  int             hold_off_cycles;
  int             idle_cycles;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Assign canonical codes in order of (length, symbol).
  task automatic assign_codes();
    int unsigned rank;
    int unsigned slot[chc_pkg::NLEN];
    bit [31:0]   code;
    int unsigned cur;
    int unsigned nxt;
    int unsigned grow;
    rank = 0;
    code = 0;
    for (int l = 0; l < chc_pkg::NLEN; l++) len_count[l] = 0;
    for (int s = 0; s < 256; s++)
      if (sym_present[s]) len_count[sym_len[s] % chc_pkg::NLEN]++;
    for (int l = 0; l < chc_pkg::NLEN; l++) begin
      len_first_rank[l] = rank;
      slot[l] = rank;
      rank += len_count[l];
    end
    for (int s = 0; s < 256; s++) begin
      if (sym_present[s]) begin
        cur = sym_len[s] % chc_pkg::NLEN;
        rank_symbol[slot[cur] & 255] = s[7:0];
        slot[cur]++;
      end
    end
    for (int i = 0; i < rank && i < 256; i++) begin
      cur = sym_len[rank_symbol[i]] % chc_pkg::NLEN;
      nxt = cur;
      sym_code[rank_symbol[i]] = code;
      if (i == len_first_rank[cur]) len_first_code[cur] = code;
      if (i + 1 < rank && i + 1 < 256) nxt = sym_len[rank_symbol[i + 1]] % chc_pkg::NLEN;
      grow = (nxt >= cur) ? nxt - cur : 0;
      code = (grow >= 32) ? 32'd0 : (code + 32'd1) << grow;
    end
    table_built = 1'b1;
  endtask

  // Predict the result of one beat and update the shadow table.
  task automatic predict_table_op(input chc_pkg::in_item_t item);
    chc_pkg::out_item_t res;
    bit [31:0]   diff;
    int unsigned l;
    res = '0;
    case (item.cmd)
      chc_pkg::CMD_LOAD: begin
        if (item.word_len > chc_pkg::MAX_LEN) begin
          res.status = chc_pkg::ST_TOO_LONG;
        end else begin
          sym_present[item.symbol] = 1'b1;
          sym_len[item.symbol] = item.word_len;
          table_built = 1'b0;
        end
      end
      chc_pkg::CMD_BUILD: assign_codes();
      chc_pkg::CMD_ENCODE: begin
        if (!table_built) begin
          res.status = chc_pkg::ST_NOT_BUILT;
        end else if (!sym_present[item.symbol]) begin
          res.status = chc_pkg::ST_NOT_FOUND;
        end else begin
          res.out_code = sym_code[item.symbol];
          res.out_length = sym_len[item.symbol];
        end
      end
      chc_pkg::CMD_DECODE: begin
        if (!table_built) begin
          res.status = chc_pkg::ST_NOT_BUILT;
        end else if (item.word_len > chc_pkg::MAX_LEN) begin
          res.status = chc_pkg::ST_TOO_LONG;
        end else begin
          l = 32'(item.word_len);
          diff = item.code_bits - len_first_code[l];
          if (len_count[l] != 0 && diff < len_count[l])
            res.found_symbol = rank_symbol[(len_first_rank[l] + diff) & 255];
          else
            res.status = chc_pkg::ST_NOT_FOUND;
        end
      end
      chc_pkg::CMD_CLEAR: begin
        for (int s = 0; s < 256; s++) sym_present[s] = 1'b0;
        for (int k = 0; k < chc_pkg::NLEN; k++) len_count[k] = 0;
        table_built = 1'b0;
      end
      default: ;
    endcase
    pending_results = {pending_results, res};
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Offer one beat, idling first at random, and hold it until accepted.
  // Valid stays high after acceptance until the next idle cycle or a stop.
  task automatic send_beat(input chc_pkg::in_item_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_table_op(item);
  endtask

  function automatic chc_pkg::in_item_t make_beat(input logic [2:0] cmd, input int sym,
                                                  input int len, input logic [31:0] bits);
    chc_pkg::in_item_t item;
    item.cmd = cmd;
    item.symbol = sym[7:0];
    item.word_len = len[5:0];
    item.code_bits = bits;
    return item;
  endfunction

  // Wait for all predictions to be met; with one result per beat nothing lingers.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Random content, mostly of legal length, that sometimes overflows the table.
  task automatic load_random_set(input int count, input int max_len);
    for (int i = 0; i < count; i++)
      send_beat(make_beat(chc_pkg::CMD_LOAD, $urandom_range(255), $urandom_range(max_len),
                          $urandom));
  endtask

  task automatic query_random(input int count);
    int sym;
    int len;
    logic [31:0] bits;
    for (int i = 0; i < count; i++) begin
      sym = $urandom_range(255);
      if ($urandom_range(1)) begin
        send_beat(make_beat(chc_pkg::CMD_ENCODE, sym, 0, $urandom));
      end else begin
        len = ($urandom_range(9) == 0) ? $urandom_range(63) : sym_len[sym];
        // Steer most decodes onto a real code word.
        bits = ($urandom_range(3) != 0 && sym_present[sym]) ? sym_code[sym] : $urandom;
        if ($urandom_range(7) == 0) bits = bits + $urandom_range(3);
        send_beat(make_beat(chc_pkg::CMD_DECODE, sym, len, bits));
      end
    end
  endtask

  task automatic test_directed();
    send_beat(make_beat(chc_pkg::CMD_ENCODE, 0, 0, 0));
    send_beat(make_beat(chc_pkg::CMD_DECODE, 0, 0, 0));
    send_beat(make_beat(chc_pkg::CMD_BUILD, 0, 0, 0));
    send_beat(make_beat(chc_pkg::CMD_DECODE, 0, 1, 0));
    send_beat(make_beat(chc_pkg::CMD_LOAD, 255, 33, 0));
    send_beat(make_beat(chc_pkg::CMD_LOAD, 0, 63, 0));
    send_beat(make_beat(chc_pkg::CMD_LOAD, 0, 0, 0));
    send_beat(make_beat(chc_pkg::CMD_LOAD, 255, 32, 0));
    send_beat(make_beat(chc_pkg::CMD_LOAD, 65, 2, 0));
    send_beat(make_beat(chc_pkg::CMD_LOAD, 66, 2, 0));
    send_beat(make_beat(chc_pkg::CMD_LOAD, 66, 3, 0));
    send_beat(make_beat(chc_pkg::CMD_LOAD, 67, 3, 0));
    send_beat(make_beat(chc_pkg::CMD_BUILD, 0, 0, 0));
    send_beat(make_beat(chc_pkg::CMD_ENCODE, 255, 0, 0));
    send_beat(make_beat(chc_pkg::CMD_ENCODE, 66, 0, 0));
    send_beat(make_beat(chc_pkg::CMD_ENCODE, 1, 0, 0));
    send_beat(make_beat(chc_pkg::CMD_DECODE, 0, 63, 0));
    send_beat(make_beat(chc_pkg::CMD_DECODE, 0, 3, sym_code[67]));
    send_beat(make_beat(chc_pkg::CMD_DECODE, 0, 32, 32'hFFFF_FFFF));
    send_beat(make_beat(chc_pkg::CMD_DECODE, 0, 32, sym_code[255]));
    send_beat(make_beat(chc_pkg::CMD_LOAD, 3, 1, 0));
    send_beat(make_beat(chc_pkg::CMD_ENCODE, 3, 0, 0));
    send_beat(make_beat(3'd7, 255, 63, 32'hFFFF_FFFF));
    send_beat(make_beat(3'd5, 0, 0, 0));
    send_beat(make_beat(chc_pkg::CMD_CLEAR, 0, 0, 0));
  endtask

  // Rounds of clear, load, build and queries; every eighth round loads all symbols.
  task automatic test_random_rounds(input int rounds);
    for (int r = 0; r < rounds; r++) begin
      send_beat(make_beat(chc_pkg::CMD_CLEAR, 0, 0, 0));
      if (r % 8 == 7) begin
        for (int s = 0; s < 256; s++)
          send_beat(make_beat(chc_pkg::CMD_LOAD, s, $urandom_range(8, 32), 0));
      end else begin
        load_random_set($urandom_range(2, 20), (r % 3 == 0) ? 63 : 12);
      end
      if ($urandom_range(5) == 0) query_random(2);
      send_beat(make_beat(chc_pkg::CMD_BUILD, 0, 0, 0));
      query_random($urandom_range(8, 26));
      if ($urandom_range(5) == 0)
        send_beat(make_beat(3'($urandom_range(5, 7)), $urandom, $urandom, $urandom));
    end
  endtask

  // Result side stays off for a long stretch while beats keep coming.
  task automatic test_backpressure();
    hold_off_cycles = 200;
    query_random(10);
    in_valid <= 1'b0;
    wait (hold_off_cycles == 0);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    error_count = 0;
    hold_off_cycles = 0;
    table_built = 1'b0;
    for (int s = 0; s < 256; s++) sym_present[s] = 1'b0;
    for (int k = 0; k < chc_pkg::NLEN; k++) len_count[k] = 0;
    send_idle_pct = 30;
    recv_idle_pct = 87;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_rounds(10);
    send_idle_pct = 87;
    recv_idle_pct = 30;
    test_random_rounds(10);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_backpressure();
    test_random_rounds(10);
    drain();

    if (error_count == 0) begin
      $display("PASS canonical_huffman_table");
    end else begin
      $display("FAIL canonical_huffman_table");
    end
    $finish;
  end

  // Receiver readiness, with the long hold-off counted down here.
  always @(posedge clk) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Each result beat is checked against the oldest prediction.
  always @(posedge clk) begin
    chc_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected beat", 32'(out_data.status), 32'd0);
      end else begin
        want = pending_results.pop_front();
        if (out_data.found_symbol !== want.found_symbol)
          report_mismatch("found_symbol", 32'(out_data.found_symbol),
                          32'(want.found_symbol));
        if (out_data.out_code !== want.out_code)
          report_mismatch("out_code", out_data.out_code, want.out_code);
        if (out_data.out_length !== want.out_length)
          report_mismatch("out_length", 32'(out_data.out_length), 32'(want.out_length));
        if (out_data.status !== want.status)
          report_mismatch("status", 32'(out_data.status), 32'(want.status));
      end
    end
  end

  // Watchdog: the run fails once the idle count outside a hold-off reaches WATCHDOG_LIMIT.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || hold_off_cycles > 0) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL canonical_huffman_table");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial idle_cycles = 0;

endmodule
